FILE: src/rhtt_pkg.sv
// shared types, codes and sizing constants for the recycled handle triplet table
// used by every module of the block except rhtt_ram; no dependencies
package rhtt_pkg;

  localparam int MAX_ENTRIES_DEF   = 1024;
  localparam int MAX_PARTICLES_DEF = 65536;
  localparam int MAX_TYPES_DEF     = 16;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_POS    = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PARTICLE = 3'd1;
  localparam logic [2:0] ST_REPEAT   = 3'd2;
  localparam logic [2:0] ST_TYPE     = 3'd3;
  localparam logic [2:0] ST_NOHANDLE = 3'd4;
  localparam logic [2:0] ST_POSITION = 3'd5;
  localparam logic [2:0] ST_FULL     = 3'd6;

  localparam logic CFG_NUM_PARTICLES = 1'b0;
  localparam logic CFG_NUM_TYPES     = 1'b1;

  typedef enum logic [2:0] {
    CL_NOP,
    CL_ADD,
    CL_REJECT,
    CL_REMOVE,
    CL_GET,
    CL_POS,
    CL_CLEAR
  } cls_e;

  typedef struct packed {
    cls_e        cls;
    logic [2:0]  status;
    logic [15:0] pa;
    logic [15:0] pb;
    logic [15:0] pc;
    logic [3:0]  etype;
    logic [9:0]  handle;
    logic [9:0]  position;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  handle_out;
    logic [15:0] member_a;
    logic [15:0] member_b;
    logic [15:0] member_c;
    logic [3:0]  type_out;
    logic [10:0] live_entries;
  } res_t;

endpackage

FILE: src/rhtt_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module rhtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rhtt_front.sv
// front end: accepts transactions and classifies them, checking add requests
// depends on rhtt_pkg
module rhtt_front #(
  parameter int MAX_PARTICLES = rhtt_pkg::MAX_PARTICLES_DEF,
  parameter int MAX_TYPES     = rhtt_pkg::MAX_TYPES_DEF
) (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       operation_i,
  input  logic [15:0]      particle_a_i,
  input  logic [15:0]      particle_b_i,
  input  logic [15:0]      particle_c_i,
  input  logic [3:0]       entry_type_i,
  input  logic [9:0]       handle_i,
  input  logic [9:0]       position_i,
  input  logic [16:0]      num_particles_i,
  input  logic [4:0]       num_types_i,
  input  logic             full_i,
  output logic             push_o,
  output rhtt_pkg::cmd_t   cmd_o
);

  localparam int PB = $clog2(MAX_PARTICLES + 1);
  localparam int PW = (PB > 17 ? PB : 17) + 1;
  localparam int TB = $clog2(MAX_TYPES + 1);
  localparam int TW = (TB > 5 ? TB : 5) + 1;

  logic p_bad, rep, t_bad;

  function automatic logic p_ok(input logic [15:0] p, input logic [16:0] np);
    p_ok = (PW'(p) < PW'(np)) && (PW'(p) < PW'(MAX_PARTICLES));
  endfunction

  always_comb begin
    p_bad = !p_ok(particle_a_i, num_particles_i) || !p_ok(particle_b_i, num_particles_i) ||
            !p_ok(particle_c_i, num_particles_i);
    rep   = (particle_a_i == particle_b_i) || (particle_a_i == particle_c_i) ||
            (particle_b_i == particle_c_i);
    t_bad = (TW'(entry_type_i) >= TW'(num_types_i)) || (TW'(entry_type_i) >= TW'(MAX_TYPES));

    cmd_o.status   = rhtt_pkg::ST_OK;
    cmd_o.pa       = particle_a_i;
    cmd_o.pb       = particle_b_i;
    cmd_o.pc       = particle_c_i;
    cmd_o.etype    = entry_type_i;
    cmd_o.handle   = handle_i;
    cmd_o.position = position_i;
    unique case (operation_i)
      rhtt_pkg::OP_ADD: begin
        if (p_bad) begin
          cmd_o.cls    = rhtt_pkg::CL_REJECT;
          cmd_o.status = rhtt_pkg::ST_PARTICLE;
        end else if (rep) begin
          cmd_o.cls    = rhtt_pkg::CL_REJECT;
          cmd_o.status = rhtt_pkg::ST_REPEAT;
        end else if (t_bad) begin
          cmd_o.cls    = rhtt_pkg::CL_REJECT;
          cmd_o.status = rhtt_pkg::ST_TYPE;
        end else begin
          cmd_o.cls = rhtt_pkg::CL_ADD;
        end
      end
      rhtt_pkg::OP_REMOVE: cmd_o.cls = rhtt_pkg::CL_REMOVE;
      rhtt_pkg::OP_GET:    cmd_o.cls = rhtt_pkg::CL_GET;
      rhtt_pkg::OP_POS:    cmd_o.cls = rhtt_pkg::CL_POS;
      rhtt_pkg::OP_CLEAR:  cmd_o.cls = rhtt_pkg::CL_CLEAR;
      default:             cmd_o.cls = rhtt_pkg::CL_NOP;
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

FILE: src/rhtt_queue.sv
// short command queue between the front end and the back end
// depends on rhtt_pkg
module rhtt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rhtt_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output rhtt_pkg::cmd_t cmd_o
);

  localparam int QD = rhtt_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  rhtt_pkg::cmd_t  slots_q [QD];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(QD));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QD - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(QD - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= cmd_i;
    end
  end

endmodule

FILE: src/rhtt_back.sv
// back end: sequencer over the entry, reverse map and free handle memories,
// with the result register; depends on rhtt_pkg and rhtt_ram
module rhtt_back #(
  parameter int MAX_ENTRIES = rhtt_pkg::MAX_ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  rhtt_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rhtt_pkg::res_t res_o
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (IW > 10 ? IW : 10) + (CW > 10 ? CW : 10) + 1;
  localparam int EW = 52;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_ADDW = 3'd2;
  localparam logic [2:0] S_SLOT = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_MOVE = 3'd5;
  localparam logic [2:0] S_POSR = 3'd6;

  logic [2:0]     state_q, state_d;
  rhtt_pkg::cmd_t cmd_q, cmd_d;
  logic [IW-1:0]  slot_q, slot_d, nh_q, nh_d;
  logic [CW-1:0]  count_q, count_d, top_q, top_d, last;
  logic           out_valid_q, out_valid_d;
  rhtt_pkg::res_t res_q, res_d, res_n;
  logic           load, out_free, fin_rem;

  logic           ent_we, has_we, soh_we, fr_we;
  logic [IW-1:0]  ent_wa, has_wa, soh_wa, fr_wa;
  logic [IW-1:0]  ent_ra, has_ra, soh_ra, fr_ra;
  logic [EW-1:0]  ent_wd, ent_rd;
  logic [IW-1:0]  has_wd, has_rd, soh_wd, soh_rd, fr_wd, fr_rd;

  logic [XW-1:0]  hx_in, px_in, hx_q;
  logic [IW-1:0]  h_in_idx, p_in_idx, h_q_idx;

  assign hx_in    = XW'(cmd_i.handle);
  assign px_in    = XW'(cmd_i.position);
  assign hx_q     = XW'(cmd_q.handle);
  assign h_in_idx = hx_in[IW-1:0];
  assign p_in_idx = px_in[IW-1:0];
  assign h_q_idx  = hx_q[IW-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign last     = count_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    slot_d      = slot_q;
    nh_d        = nh_q;
    count_d     = count_q;
    top_d       = top_q;
    pop_o       = 1'b0;
    load        = 1'b0;
    fin_rem     = 1'b0;
    res_n       = '0;
    ent_we = 1'b0; has_we = 1'b0; soh_we = 1'b0; fr_we = 1'b0;
    ent_wa = '0;   has_wa = '0;   soh_wa = '0;   fr_wa = '0;
    ent_ra = '0;   has_ra = '0;   soh_ra = '0;   fr_ra = '0;
    ent_wd = '0;   has_wd = '0;   soh_wd = '0;   fr_wd = '0;

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          cmd_d = cmd_i;
          unique case (cmd_i.cls)
            rhtt_pkg::CL_ADD: begin
              if (count_q >= CW'(MAX_ENTRIES)) begin
                load         = 1'b1;
                res_n.status = rhtt_pkg::ST_FULL;
              end else if (top_q != '0) begin
                fr_ra   = IW'(top_q - CW'(1));
                top_d   = top_q - CW'(1);
                state_d = S_POP;
              end else begin
                nh_d    = IW'(count_q);
                state_d = S_ADDW;
              end
            end
            rhtt_pkg::CL_REMOVE, rhtt_pkg::CL_GET: begin
              if (hx_in < XW'(MAX_ENTRIES) && hx_in < XW'(count_q) + XW'(top_q)) begin
                soh_ra  = h_in_idx;
                state_d = S_SLOT;
              end else begin
                load         = 1'b1;
                res_n.status = rhtt_pkg::ST_NOHANDLE;
              end
            end
            rhtt_pkg::CL_POS: begin
              if (px_in < XW'(count_q)) begin
                has_ra  = p_in_idx;
                state_d = S_POSR;
              end else begin
                load         = 1'b1;
                res_n.status = rhtt_pkg::ST_POSITION;
              end
            end
            rhtt_pkg::CL_CLEAR: begin
              count_d = '0;
              top_d   = '0;
              load    = 1'b1;
            end
            rhtt_pkg::CL_REJECT: begin
              load         = 1'b1;
              res_n.status = cmd_i.status;
            end
            default: load = 1'b1;
          endcase
        end
      end
      S_POP: begin
        nh_d    = fr_rd;
        state_d = S_ADDW;
      end
      S_ADDW: begin
        ent_we = 1'b1;
        ent_wa = IW'(count_q);
        ent_wd = {cmd_q.etype, cmd_q.pc, cmd_q.pb, cmd_q.pa};
        has_we = 1'b1;
        has_wa = IW'(count_q);
        has_wd = nh_q;
        soh_we = 1'b1;
        soh_wa = nh_q;
        soh_wd = IW'(count_q);
        count_d          = count_q + CW'(1);
        load             = 1'b1;
        res_n.handle_out = 10'(nh_q);
        state_d          = S_IDLE;
      end
      S_SLOT: begin
        slot_d = soh_rd;
        if (CW'(soh_rd) >= count_q) begin
          load         = 1'b1;
          res_n.status = rhtt_pkg::ST_NOHANDLE;
          state_d      = S_IDLE;
        end else begin
          has_ra  = soh_rd;
          ent_ra  = soh_rd;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (has_rd != h_q_idx) begin
          load         = 1'b1;
          res_n.status = rhtt_pkg::ST_NOHANDLE;
          state_d      = S_IDLE;
        end else if (cmd_q.cls == rhtt_pkg::CL_GET) begin
          load           = 1'b1;
          res_n.member_a = ent_rd[15:0];
          res_n.member_b = ent_rd[31:16];
          res_n.member_c = ent_rd[47:32];
          res_n.type_out = ent_rd[51:48];
          state_d        = S_IDLE;
        end else if (CW'(slot_q) < last) begin
          has_ra  = IW'(last);
          ent_ra  = IW'(last);
          state_d = S_MOVE;
        end else begin
          fin_rem = 1'b1;
        end
      end
      S_MOVE: begin
        ent_we  = 1'b1;
        ent_wa  = slot_q;
        ent_wd  = ent_rd;
        has_we  = 1'b1;
        has_wa  = slot_q;
        has_wd  = has_rd;
        soh_we  = 1'b1;
        soh_wa  = has_rd;
        soh_wd  = slot_q;
        fin_rem = 1'b1;
      end
      S_POSR: begin
        load             = 1'b1;
        res_n.handle_out = 10'(has_rd);
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    if (fin_rem) begin
      count_d = last;
      if (top_q < CW'(MAX_ENTRIES)) begin
        fr_we = 1'b1;
        fr_wa = IW'(top_q);
        fr_wd = h_q_idx;
        top_d = top_q + CW'(1);
      end
      load    = 1'b1;
      state_d = S_IDLE;
    end

    res_n.live_entries = 11'(count_d);
    res_d       = load ? res_n : res_q;
    out_valid_d = load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    slot_q <= slot_d;
    nh_q   <= nh_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  rhtt_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entries (
    .clk_i, .we_i(ent_we), .waddr_i(ent_wa), .wdata_i(ent_wd), .raddr_i(ent_ra),
    .rdata_o(ent_rd)
  );

  rhtt_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_handle_at_slot (
    .clk_i, .we_i(has_we), .waddr_i(has_wa), .wdata_i(has_wd), .raddr_i(has_ra),
    .rdata_o(has_rd)
  );

  rhtt_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_slot_of_handle (
    .clk_i, .we_i(soh_we), .waddr_i(soh_wa), .wdata_i(soh_wd), .raddr_i(soh_ra),
    .rdata_o(soh_rd)
  );

  rhtt_ram #(.WIDTH(IW), .DEPTH(MAX_ENTRIES)) u_freed (
    .clk_i, .we_i(fr_we), .waddr_i(fr_wa), .wdata_i(fr_wd), .raddr_i(fr_ra),
    .rdata_o(fr_rd)
  );

endmodule

FILE: src/recycled_handle_triplet_table_core.sv
// top level of the recycled handle triplet table: configuration registers,
// front end, command queue and back end; depends on rhtt_pkg and all rhtt modules
//
// Operations enter through a two-deep queue and run one at a time in the back end.
// A rejected add, a full table, an unknown operation, clear and every early
// error finish in the idle state; handle at position first reads the reverse map;
// add pops the free handle memory first only for a recycled handle; get and remove
// read the slot, then check the handle, and remove may move the last entry into the
// hole. The back end chains these registered reads of the slot, reverse map and free handle memories.
module recycled_handle_triplet_table_core #(
  parameter int MAX_ENTRIES   = rhtt_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_PARTICLES = rhtt_pkg::MAX_PARTICLES_DEF,
  parameter int MAX_TYPES     = rhtt_pkg::MAX_TYPES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] particle_a_i,
  input  logic [15:0] particle_b_i,
  input  logic [15:0] particle_c_i,
  input  logic [3:0]  entry_type_i,
  input  logic [9:0]  handle_i,
  input  logic [9:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [9:0]  handle_out_o,
  output logic [15:0] member_a_o,
  output logic [15:0] member_b_o,
  output logic [15:0] member_c_o,
  output logic [3:0]  type_out_o,
  output logic [10:0] live_entries_o
);

  logic [16:0]    num_particles_q;
  logic [4:0]     num_types_q;
  logic           push, full, pop, empty;
  rhtt_pkg::cmd_t f_cmd, q_cmd;
  rhtt_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_particles_q <= '0;
      num_types_q     <= 5'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == rhtt_pkg::CFG_NUM_PARTICLES) begin
        num_particles_q <= cfg_data_i;
      end else begin
        num_types_q <= cfg_data_i[4:0];
      end
    end
  end

  rhtt_front #(.MAX_PARTICLES(MAX_PARTICLES), .MAX_TYPES(MAX_TYPES)) u_front (
    .in_valid_i, .in_stall_o, .operation_i, .particle_a_i, .particle_b_i,
    .particle_c_i, .entry_type_i, .handle_i, .position_i,
    .num_particles_i(num_particles_q), .num_types_i(num_types_q),
    .full_i(full), .push_o(push), .cmd_o(f_cmd)
  );

  rhtt_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(f_cmd), .full_o(full),
    .pop_i(pop), .empty_o(empty), .cmd_o(q_cmd)
  );

  rhtt_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(q_cmd), .pop_o(pop),
    .out_valid_o, .out_stall_i, .res_o(res)
  );

  assign status_o       = res.status;
  assign handle_out_o   = res.handle_out;
  assign member_a_o     = res.member_a;
  assign member_b_o     = res.member_b;
  assign member_c_o     = res.member_c;
  assign type_out_o     = res.type_out;
  assign live_entries_o = res.live_entries;

endmodule
